// ----- design/gqdp_pkg.sv -----
// Shared widths, defaults, register codes and helpers for the group quantized dot product.
package gqdp_pkg;

	localparam int VALUE_W          = 8;
	localparam int SCALE_W          = 32;
	localparam int FRAC_BITS        = 30;
	localparam int PROD_SCALE_W     = 2 * SCALE_W;
	localparam int SCALE_Q_W        = PROD_SCALE_W - FRAC_BITS;
	localparam int SUM_W            = 64;
	localparam int INDEX_W          = 18;

	localparam int GROUP_SIZE_W     = 9;
	localparam int GROUPS_PER_ROW_W = 11;
	localparam int CFG_INDEX_W      = 1;
	localparam int CFG_DATA_W       = 11;

	localparam logic [GROUP_SIZE_W-1:0]     GROUP_SIZE_RESET     = 9'd64;
	localparam logic [GROUPS_PER_ROW_W-1:0] GROUPS_PER_ROW_RESET = 11'd64;

	localparam int DEF_MAX_GROUP_SIZE     = 256;
	localparam int DEF_MAX_GROUPS_PER_ROW = 1024;
	localparam int DEF_MAX_ROWS           = 262144;

	localparam int QUEUE_AW = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_GROUP_SIZE     = 1'b0,
		REG_GROUPS_PER_ROW = 1'b1
	} cfg_reg_t;

	// A product of two int8 values has magnitude at most 2^14, so a group of
	// max_gs elements needs 16 + clog2(max_gs) signed bits.
	function automatic int gacc_width(input int max_gs);
		return 2 * VALUE_W + $clog2(max_gs);
	endfunction

	function automatic int count_width(input int max_count);
		return (max_count > 1) ? $clog2(max_count) : 1;
	endfunction

endpackage

// ----- design/gqdp_fifo.sv -----
// Small register queue with registered pointers and a fill count.
module gqdp_fifo #(
	parameter int WIDTH = 8,
	parameter int AW    = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int DEPTH = 1 << AW;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (AW + 1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/gqdp_front.sv -----
// Front end: configuration registers, element and group counting, exact group sums.
module gqdp_front
	import gqdp_pkg::*;
#(
	parameter int MAX_GROUP_SIZE     = DEF_MAX_GROUP_SIZE,
	parameter int MAX_GROUPS_PER_ROW = DEF_MAX_GROUPS_PER_ROW,
	parameter int GACC_W             = gacc_width(DEF_MAX_GROUP_SIZE)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_INDEX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     push,
	input  logic signed [VALUE_W-1:0] act_value,
	input  logic signed [VALUE_W-1:0] weight_value,
	input  logic [SCALE_W-1:0]       act_scale,
	input  logic [SCALE_W-1:0]       weight_scale,
	input  logic                     q_full,
	output logic                     q_push,
	output logic signed [GACC_W-1:0] q_gacc,
	output logic [SCALE_W-1:0]       q_act_scale,
	output logic [SCALE_W-1:0]       q_weight_scale,
	output logic                     q_row_last
);

	localparam int EW   = count_width(MAX_GROUP_SIZE);
	localparam int GSW  = $clog2(MAX_GROUP_SIZE + 1);
	localparam int GCW  = (GSW > GROUP_SIZE_W) ? GSW : GROUP_SIZE_W;
	localparam int GW   = count_width(MAX_GROUPS_PER_ROW);
	localparam int GPSW = $clog2(MAX_GROUPS_PER_ROW + 1);
	localparam int GPCW = (GPSW > GROUPS_PER_ROW_W) ? GPSW : GROUPS_PER_ROW_W;

	logic [GROUP_SIZE_W-1:0]     group_size_q;
	logic [GROUPS_PER_ROW_W-1:0] groups_per_row_q;
	logic [EW-1:0]               elem_cnt_q;
	logic [GW-1:0]               group_cnt_q;
	logic signed [GACC_W-1:0]    gacc_q;

	logic [GCW-1:0]              gs_ext;
	logic [GCW-1:0]              gs_eff;
	logic [GPCW-1:0]             gpr_ext;
	logic [GPCW-1:0]             gpr_eff;
	logic                        accept;
	logic                        last_elem;
	logic                        last_group;
	logic signed [2*VALUE_W-1:0] prod;
	logic signed [GACC_W-1:0]    gacc_next;

	// Out-of-range settings act as the nearest legal value.
	always_comb begin
		gs_ext = GCW'(group_size_q);
		if (gs_ext == '0) begin
			gs_eff = GCW'(1);
		end else if (gs_ext > GCW'(MAX_GROUP_SIZE)) begin
			gs_eff = GCW'(MAX_GROUP_SIZE);
		end else begin
			gs_eff = gs_ext;
		end
		gpr_ext = GPCW'(groups_per_row_q);
		if (gpr_ext == '0) begin
			gpr_eff = GPCW'(1);
		end else if (gpr_ext > GPCW'(MAX_GROUPS_PER_ROW)) begin
			gpr_eff = GPCW'(MAX_GROUPS_PER_ROW);
		end else begin
			gpr_eff = gpr_ext;
		end
	end

	assign accept     = push && !q_full;
	assign last_elem  = (GCW'(elem_cnt_q) + GCW'(1)) >= gs_eff;
	assign last_group = (GPCW'(group_cnt_q) + GPCW'(1)) >= gpr_eff;
	assign prod       = act_value * weight_value;
	assign gacc_next  = gacc_q + GACC_W'(prod);

	assign q_push         = accept && last_elem;
	assign q_gacc         = gacc_next;
	assign q_act_scale    = act_scale;
	assign q_weight_scale = weight_scale;
	assign q_row_last     = last_group;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q     <= GROUP_SIZE_RESET;
			groups_per_row_q <= GROUPS_PER_ROW_RESET;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_GROUP_SIZE: begin
					group_size_q <= cfg_data[GROUP_SIZE_W-1:0];
				end
				REG_GROUPS_PER_ROW: begin
					groups_per_row_q <= cfg_data[GROUPS_PER_ROW_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_cnt_q  <= '0;
			group_cnt_q <= '0;
			gacc_q      <= '0;
		end else if (accept) begin
			if (last_elem) begin
				elem_cnt_q <= '0;
				gacc_q     <= '0;
				if (last_group) begin
					group_cnt_q <= '0;
				end else begin
					group_cnt_q <= GW'(group_cnt_q + 1'b1);
				end
			end else begin
				elem_cnt_q <= EW'(elem_cnt_q + 1'b1);
				gacc_q     <= gacc_next;
			end
		end
	end

endmodule

// ----- design/gqdp_back.sv -----
// Back end: scale product, scaled group term and saturating row accumulation.
module gqdp_back
	import gqdp_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int GACC_W   = gacc_width(DEF_MAX_GROUP_SIZE)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  logic signed [GACC_W-1:0] q_gacc,
	input  logic [SCALE_W-1:0]       q_act_scale,
	input  logic [SCALE_W-1:0]       q_weight_scale,
	input  logic                     q_row_last,
	output logic                     q_pop,
	input  logic                     res_full,
	output logic                     res_push,
	output logic signed [SUM_W-1:0]  res_row_sum,
	output logic [INDEX_W-1:0]       res_row_index
);

	localparam int ABS_W = GACC_W - 1;
	localparam int MAG_W = ABS_W + SCALE_Q_W;
	localparam int RW    = count_width(MAX_ROWS);

	logic                     v_s1;
	logic signed [GACC_W-1:0] gacc_s1;
	logic [SCALE_W-1:0]       act_scale_s1;
	logic [SCALE_W-1:0]       weight_scale_s1;
	logic                     last_s1;

	logic                     v_s2;
	logic [PROD_SCALE_W-1:0]  prod_s2;
	logic [ABS_W-1:0]         abs_s2;
	logic                     neg_s2;
	logic                     last_s2;

	logic                     v_s3;
	logic [MAG_W-1:0]         mag_s3;
	logic                     neg_s3;
	logic                     last_s3;

	logic signed [SUM_W-1:0]  row_acc_q;
	logic [RW-1:0]            row_cnt_q;

	logic                     advance;
	logic signed [GACC_W-1:0] gacc_neg;
	logic [ABS_W-1:0]         gacc_abs;
	logic [PROD_SCALE_W-1:0]  scale_prod;
	logic [SCALE_Q_W-1:0]     scale_q;
	logic [MAG_W-1:0]         mag;
	logic signed [SUM_W-1:0]  term;
	logic signed [SUM_W:0]    sum_wide;
	logic signed [SUM_W-1:0]  sum_sat;

	// The whole pipeline holds only when a finished row cannot enter the result queue.
	assign advance = !(v_s3 && last_s3 && res_full);
	assign q_pop   = q_valid && advance;

	assign gacc_neg   = -gacc_s1;
	assign gacc_abs   = gacc_s1[GACC_W-1] ? gacc_neg[ABS_W-1:0] : gacc_s1[ABS_W-1:0];
	assign scale_prod = act_scale_s1 * weight_scale_s1;
	assign scale_q    = prod_s2[PROD_SCALE_W-1:FRAC_BITS];
	assign mag        = MAG_W'(abs_s2) * MAG_W'(scale_q);

	always_comb begin
		term     = neg_s3 ? -SUM_W'(mag_s3) : SUM_W'(mag_s3);
		sum_wide = {row_acc_q[SUM_W-1], row_acc_q} + {term[SUM_W-1], term};
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
				: {1'b0, {(SUM_W - 1){1'b1}}};
		end else begin
			sum_sat = sum_wide[SUM_W-1:0];
		end
	end

	assign res_push      = v_s3 && last_s3 && advance;
	assign res_row_sum   = sum_sat;
	assign res_row_index = INDEX_W'(row_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= q_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gacc_s1         <= q_gacc;
			act_scale_s1    <= q_act_scale;
			weight_scale_s1 <= q_weight_scale;
			last_s1         <= q_row_last;
			prod_s2         <= scale_prod;
			abs_s2          <= gacc_abs;
			neg_s2          <= gacc_s1[GACC_W-1];
			last_s2         <= last_s1;
			mag_s3          <= mag;
			neg_s3          <= neg_s2;
			last_s3         <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_acc_q <= '0;
			row_cnt_q <= '0;
		end else if (v_s3 && advance) begin
			if (last_s3) begin
				row_acc_q <= '0;
				if (row_cnt_q == RW'(MAX_ROWS - 1)) begin
					row_cnt_q <= '0;
				end else begin
					row_cnt_q <= RW'(row_cnt_q + 1'b1);
				end
			end else begin
				row_acc_q <= sum_sat;
			end
		end
	end

endmodule

// ----- design/group_quantized_dot_product.sv -----
// Top level of the group quantized int8 dot product engine.
//
// Input channel: one activation/weight pair per beat, with the pair of group
// scales; a beat is taken when push is high and full is low. The scales are
// used only on the last element of each group. Results leave through a queue:
// while empty is low, row_sum and row_index hold the oldest row result, and a
// beat is taken when pop is high and empty is low.
// Throughput is one input beat per cycle while full is low. The front end sums
// each group exactly and hands one record per group to the back end through a
// four-entry queue; the back end runs a three-stage pipeline (scale product,
// scaled term, saturating row add) that takes one group record per cycle unless
// a finished row meets a full result queue. A row result reaches the result
// ports once its last group record passes both queues and the back-end stages.
// When the receiver stalls, results collect in a four-entry queue; once it is
// full the back end holds, the group queue fills, and full rises to stop input.
// Reset clears all counters and accumulators and both queues, and sets both
// group_size and groups_per_row to 64. Configuration writes take effect at once.
module group_quantized_dot_product
	import gqdp_pkg::*;
#(
	parameter int MAX_GROUP_SIZE     = DEF_MAX_GROUP_SIZE,
	parameter int MAX_GROUPS_PER_ROW = DEF_MAX_GROUPS_PER_ROW,
	parameter int MAX_ROWS           = DEF_MAX_ROWS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      push,
	output logic                      full,
	input  logic signed [VALUE_W-1:0] act_value,
	input  logic signed [VALUE_W-1:0] weight_value,
	input  logic [SCALE_W-1:0]        act_scale,
	input  logic [SCALE_W-1:0]        weight_scale,
	output logic                      empty,
	input  logic                      pop,
	output logic signed [SUM_W-1:0]   row_sum,
	output logic [INDEX_W-1:0]        row_index
);

	localparam int GACC_W = gacc_width(MAX_GROUP_SIZE);
	localparam int GRP_W  = GACC_W + 2 * SCALE_W + 1;
	localparam int RES_W  = SUM_W + INDEX_W;

	logic                     fq_push;
	logic signed [GACC_W-1:0] fq_gacc;
	logic [SCALE_W-1:0]       fq_act_scale;
	logic [SCALE_W-1:0]       fq_weight_scale;
	logic                     fq_row_last;
	logic                     grp_full;
	logic                     grp_empty;
	logic                     grp_pop;
	logic [GRP_W-1:0]         grp_rdata;

	logic signed [GACC_W-1:0] bq_gacc;
	logic [SCALE_W-1:0]       bq_act_scale;
	logic [SCALE_W-1:0]       bq_weight_scale;
	logic                     bq_row_last;

	logic                     res_full;
	logic                     res_push;
	logic signed [SUM_W-1:0]  res_row_sum;
	logic [INDEX_W-1:0]       res_row_index;
	logic [RES_W-1:0]         res_rdata;

	assign full = grp_full;

	gqdp_front #(
		.MAX_GROUP_SIZE     (MAX_GROUP_SIZE),
		.MAX_GROUPS_PER_ROW (MAX_GROUPS_PER_ROW),
		.GACC_W             (GACC_W)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.act_value      (act_value),
		.weight_value   (weight_value),
		.act_scale      (act_scale),
		.weight_scale   (weight_scale),
		.q_full         (grp_full),
		.q_push         (fq_push),
		.q_gacc         (fq_gacc),
		.q_act_scale    (fq_act_scale),
		.q_weight_scale (fq_weight_scale),
		.q_row_last     (fq_row_last)
	);

	gqdp_fifo #(
		.WIDTH (GRP_W),
		.AW    (QUEUE_AW)
	) u_group_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.wdata  ({fq_gacc, fq_act_scale, fq_weight_scale, fq_row_last}),
		.full   (grp_full),
		.pop    (grp_pop),
		.rdata  (grp_rdata),
		.empty  (grp_empty)
	);

	assign {bq_gacc, bq_act_scale, bq_weight_scale, bq_row_last} = grp_rdata;

	gqdp_back #(
		.MAX_ROWS (MAX_ROWS),
		.GACC_W   (GACC_W)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (!grp_empty),
		.q_gacc         (bq_gacc),
		.q_act_scale    (bq_act_scale),
		.q_weight_scale (bq_weight_scale),
		.q_row_last     (bq_row_last),
		.q_pop          (grp_pop),
		.res_full       (res_full),
		.res_push       (res_push),
		.res_row_sum    (res_row_sum),
		.res_row_index  (res_row_index)
	);

	gqdp_fifo #(
		.WIDTH (RES_W),
		.AW    (QUEUE_AW)
	) u_result_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  ({res_row_sum, res_row_index}),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign {row_sum, row_index} = res_rdata;

endmodule

// ----- verif/tb_group_quantized_dot_product.sv -----
// Self-checking testbench for the group quantized int8 dot product engine.
module tb_group_quantized_dot_product;
	timeunit 1ns;
	timeprecision 1ps;

	import gqdp_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int RANDOM_BEATS   = 1425;

	typedef enum int {MIX_UNIFORM, MIX_EXTREME, MIX_SMALL} value_mix_t;

	typedef struct {
		logic signed [SUM_W-1:0] sum;
		logic [INDEX_W-1:0]      row;
	} row_result_t;

	// Tracks the engine's counters and accumulators and queues the row sums it must produce.
	class row_sum_scoreboard;
		logic [GROUP_SIZE_W-1:0]     gs_reg;
		logic [GROUPS_PER_ROW_W-1:0] gpr_reg;
		int unsigned                 elem_cnt;
		int unsigned                 grp_cnt;
		int                          grp_acc;
		logic signed [SUM_W-1:0]     row_acc;
		logic [INDEX_W-1:0]          row_idx;
		row_result_t                 pending_rows[$];
		int                          errors;

		function new();
			gs_reg   = GROUP_SIZE_RESET;
			gpr_reg  = GROUPS_PER_ROW_RESET;
			elem_cnt = 0;
			grp_cnt  = 0;
			grp_acc  = 0;
			row_acc  = '0;
			row_idx  = '0;
			errors   = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_GROUP_SIZE: begin
					gs_reg = data[GROUP_SIZE_W-1:0];
				end
				REG_GROUPS_PER_ROW: begin
					gpr_reg = data[GROUPS_PER_ROW_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function int unsigned clamp_count(int unsigned v, int unsigned hi);
			if (v == 0)
				return 1;
			return (v > hi) ? hi : v;
		endfunction

		function int unsigned eff_group_size();
			return clamp_count(gs_reg, DEF_MAX_GROUP_SIZE);
		endfunction

		function int unsigned eff_groups_per_row();
			return clamp_count(gpr_reg, DEF_MAX_GROUPS_PER_ROW);
		endfunction

		function int unsigned beats_to_row_end();
			int unsigned gs;
			int unsigned gpr;
			int unsigned n;
			gs  = eff_group_size();
			gpr = eff_groups_per_row();
			n = (elem_cnt + 1 >= gs) ? 1 : gs - elem_cnt;
			if (grp_cnt + 1 < gpr)
				n += (gpr - grp_cnt - 1) * gs;
			return n;
		endfunction

		function void note_input(logic signed [VALUE_W-1:0] a, logic signed [VALUE_W-1:0] w,
				logic [SCALE_W-1:0] as, logic [SCALE_W-1:0] ws);
			logic [PROD_SCALE_W-1:0] scale_prod;
			logic [PROD_SCALE_W-1:0] scale;
			logic [SUM_W-1:0]        mag;
			logic signed [SUM_W-1:0] term;
			logic signed [SUM_W:0]   wide;
			grp_acc += int'(a) * int'(w);
			if (elem_cnt + 1 < eff_group_size()) begin
				elem_cnt++;
				return;
			end
			// The scale product is Q4.60; dropping 30 fraction bits truncates it to Q4.30.
			scale_prod = PROD_SCALE_W'(as) * PROD_SCALE_W'(ws);
			scale = scale_prod >> FRAC_BITS;
			if (grp_acc < 0) begin
				mag  = SUM_W'(-grp_acc) * scale;
				term = -$signed(mag);
			end else begin
				mag  = SUM_W'(grp_acc) * scale;
				term = $signed(mag);
			end
			wide = row_acc + term;
			if (wide[SUM_W] != wide[SUM_W-1])
				row_acc = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
			else
				row_acc = wide[SUM_W-1:0];
			grp_acc  = 0;
			elem_cnt = 0;
			if (grp_cnt + 1 < eff_groups_per_row()) begin
				grp_cnt++;
				return;
			end
			pending_rows.push_back('{sum: row_acc, row: row_idx});
			row_acc = '0;
			grp_cnt = 0;
			row_idx = row_idx + 1'b1;
		endfunction

		function void check_result(logic signed [SUM_W-1:0] sum, logic [INDEX_W-1:0] row);
			row_result_t want;
			if (pending_rows.size() == 0) begin
				$error("unexpected result beat: row_sum=%0d row_index=%0d", sum, row);
				errors++;
				return;
			end
			want = pending_rows.pop_front();
			if (sum !== want.sum) begin
				$error("row_sum mismatch: expected %0d, actual %0d", want.sum, sum);
				errors++;
			end
			if (row !== want.row) begin
				$error("row_index mismatch: expected %0d, actual %0d", want.row, row);
				errors++;
			end
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_write;
	logic [CFG_INDEX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;
	logic                      push;
	logic                      full;
	logic signed [VALUE_W-1:0] act_value;
	logic signed [VALUE_W-1:0] weight_value;
	logic [SCALE_W-1:0]        act_scale;
	logic [SCALE_W-1:0]        weight_scale;
	logic                      empty;
	logic                      pop;
	logic signed [SUM_W-1:0]   row_sum;
	logic [INDEX_W-1:0]        row_index;

	row_sum_scoreboard sb = new();
	bit                steady = 1'b0;
	int                quiet_cycles = 0;

	group_quantized_dot_product uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.act_value    (act_value),
		.weight_value (weight_value),
		.act_scale    (act_scale),
		.weight_scale (weight_scale),
		.empty        (empty),
		.pop          (pop),
		.row_sum      (row_sum),
		.row_index    (row_index)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Beats are sampled at the edge that takes them, before any register in the block updates.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.note_input(act_value, weight_value, act_scale, weight_scale);
			if (pop && !empty)
				sb.check_result(row_sum, row_index);
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// The receiver stalls at random except during the steady stretch.
	initial begin
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			pop <= steady || ($urandom_range(99) >= 15);
		end
	end

	function automatic bit idle_roll();
		return !steady && ($urandom_range(99) < 15);
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value(value_mix_t mix);
		case (mix)
			MIX_EXTREME: begin
				case ($urandom_range(3))
					0: return 8'h80;
					1: return 8'h7F;
					2: return 8'h00;
					default: return 8'hFF;
				endcase
			end
			MIX_SMALL: return VALUE_W'($urandom_range(6)) - 8'd3;
			default: return VALUE_W'($urandom);
		endcase
	endfunction

	function automatic logic [SCALE_W-1:0] pick_scale(value_mix_t mix);
		if (mix == MIX_EXTREME) begin
			case ($urandom_range(3))
				0: return 32'h0000_0000;
				1: return 32'hFFFF_FFFF;
				2: return 32'h4000_0000;
				default: return $urandom;
			endcase
		end
		return $urandom;
	endfunction

	task automatic send_beat(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] w,
			logic [SCALE_W-1:0] as, logic [SCALE_W-1:0] ws);
		while (idle_roll()) begin
			push         <= 1'b0;
			act_value    <= VALUE_W'($urandom);
			weight_value <= VALUE_W'($urandom);
			act_scale    <= $urandom;
			weight_scale <= $urandom;
			@(posedge clk);
		end
		push         <= 1'b1;
		act_value    <= a;
		weight_value <= w;
		act_scale    <= as;
		weight_scale <= ws;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic send_mixed(int unsigned count, value_mix_t mix);
		repeat (count)
			send_beat(pick_value(mix), pick_value(mix), pick_scale(mix), pick_scale(mix));
	endtask

	// Waits for every expected row, then lets group records still in flight retire.
	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending_rows.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		sb.write_reg(idx, data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		cfg_data  <= CFG_DATA_W'($urandom);
	endtask

	initial begin
		int unsigned random_beats;
		int unsigned phase;
		int unsigned to_end;
		int unsigned row_beats;
		int unsigned len;
		int unsigned span;
		value_mix_t  mix;
		logic [CFG_DATA_W-1:0] gs_data;
		logic [CFG_DATA_W-1:0] gpr_data;

		arst_n       <= 1'b0;
		cfg_write    <= 1'b0;
		cfg_index    <= REG_GROUP_SIZE;
		cfg_data     <= '0;
		push         <= 1'b0;
		act_value    <= '0;
		weight_value <= '0;
		act_scale    <= '0;
		weight_scale <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Partial group under the reset settings, then shrink the group and the row under it.
		send_mixed(3, MIX_UNIFORM);
		wait_idle();
		write_reg(REG_GROUP_SIZE, CFG_DATA_W'(1));
		send_mixed(1, MIX_UNIFORM);
		wait_idle();
		write_reg(REG_GROUPS_PER_ROW, CFG_DATA_W'(1));
		send_beat(8'h80, 8'h80, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_beat(8'h7F, 8'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_beat(8'h80, 8'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_beat(8'h7F, 8'h80, 32'h0000_0000, 32'hFFFF_FFFF);
		send_beat(8'h00, 8'h00, 32'hAAAA_AAAA, 32'h5555_5555);
		send_beat(8'h01, 8'h01, 32'h4000_0000, 32'h4000_0000);
		send_beat(8'hFF, 8'h01, 32'h4000_0000, 32'h4000_0000);
		send_beat(8'h05, 8'h07, 32'h0000_0001, 32'h0000_0001);
		send_beat(8'h03, 8'h03, 32'h0000_8000, 32'h0000_8000);
		send_beat(8'h55, 8'hAA, 32'h5555_5555, 32'hAAAA_AAAA);
		wait_idle();
		// Zero in either register behaves as one.
		write_reg(REG_GROUP_SIZE, CFG_DATA_W'(0));
		write_reg(REG_GROUPS_PER_ROW, CFG_DATA_W'(0));
		send_mixed(3, MIX_EXTREME);
		wait_idle();
		// Values past the maximum clamp; upper data bits beyond the group size field are noise.
		write_reg(REG_GROUP_SIZE, 11'h7FF);
		write_reg(REG_GROUPS_PER_ROW, 11'h7FF);
		send_mixed(5, MIX_UNIFORM);
		wait_idle();
		write_reg(REG_GROUP_SIZE, CFG_DATA_W'(2));
		write_reg(REG_GROUPS_PER_ROW, CFG_DATA_W'(2));
		send_mixed(1, MIX_SMALL);

		random_beats = 0;
		phase = 0;
		while (random_beats < RANDOM_BEATS) begin
			wait_idle();
			steady = (phase >= 8 && phase < 20);
			gs_data  = CFG_DATA_W'($urandom_range(1, 8)) | {2'($urandom_range(3)), 9'd0};
			gpr_data = CFG_DATA_W'($urandom_range(1, 6));
			if ($urandom_range(99) < 15) begin
				case ($urandom_range(3))
					0: gs_data = '0;
					1: gs_data = CFG_DATA_W'(1);
					2: gs_data = CFG_DATA_W'(DEF_MAX_GROUP_SIZE);
					default: gs_data = CFG_DATA_W'($urandom_range(257, 2047));
				endcase
			end
			if ($urandom_range(99) < 15) begin
				case ($urandom_range(3))
					0: gpr_data = '0;
					1: gpr_data = CFG_DATA_W'(1);
					2: gpr_data = CFG_DATA_W'(DEF_MAX_GROUPS_PER_ROW);
					default: gpr_data = CFG_DATA_W'($urandom_range(1025, 2047));
				endcase
			end
			case ($urandom_range(3))
				0: write_reg(REG_GROUP_SIZE, gs_data);
				1: write_reg(REG_GROUPS_PER_ROW, gpr_data);
				2: begin
					write_reg(REG_GROUP_SIZE, gs_data);
					write_reg(REG_GROUPS_PER_ROW, gpr_data);
				end
				default: ;
			endcase
			case ($urandom_range(99) / 15)
				0: mix = MIX_EXTREME;
				1: mix = MIX_SMALL;
				default: mix = MIX_UNIFORM;
			endcase
			to_end    = sb.beats_to_row_end();
			row_beats = sb.eff_group_size() * sb.eff_groups_per_row();
			// Some phases stop inside a group so the next setting lands mid-row.
			if ($urandom_range(99) < 30) begin
				span = (to_end < 40) ? to_end : 40;
				len = $urandom_range(1, span);
			end else begin
				len = to_end + $urandom_range(2) * row_beats;
			end
			if (len > 300)
				len = 300;
			if (len > RANDOM_BEATS - random_beats)
				len = RANDOM_BEATS - random_beats;
			send_mixed(len, mix);
			random_beats += len;
			phase++;
		end
		steady = 1'b0;

		wait_idle();
		if (sb.errors == 0 && sb.pending_rows.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
design/gqdp_pkg.sv
design/gqdp_fifo.sv
design/gqdp_front.sv
design/gqdp_back.sv
design/group_quantized_dot_product.sv
verif/tb_group_quantized_dot_product.sv
